// ===== hw/rtl/tick_slotted_message_buffer_defines.svh =====
// ---------------------------------------------------------------------------
// Tick-slotted message buffer assertion macros
// Shared concurrent assertion forms for the timing wheel RTL.
// ---------------------------------------------------------------------------
`ifndef TICK_SLOTTED_MESSAGE_BUFFER_DEFINES_SVH
`define TICK_SLOTTED_MESSAGE_BUFFER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TSMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsmb: assertion failed");

// next-cycle implication, disabled in reset
`define TSMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsmb: assertion failed");

`endif

// ===== hw/rtl/tsmb_pkg.sv =====
// ---------------------------------------------------------------------------
// Tick-slotted message buffer package
// Sizes, codes and shared types of the timing wheel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsmb_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_DEPTH = 16;

  localparam int TICK_W   = 32;
  localparam int DIFF_W   = 33;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = $clog2(NUM_SLOTS);
  localparam int IDX_W    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int FILL_W   = $clog2(SLOT_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_SLOTS * SLOT_DEPTH;
  localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [0:0] {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DIFF_W-1:0] diff;
    logic [SLOT_W-1:0]        slot;
  } check_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(slot) * ADDR_W'(SLOT_DEPTH));
    return ADDR_W'(base + ADDR_W'(idx));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsmb_ram.sv =====
// ---------------------------------------------------------------------------
// Tick-slotted message buffer store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsmb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsmb_window.sv =====
// ---------------------------------------------------------------------------
// Tick-slotted message buffer window check
// Classifies a tick against the current window and maps it to its slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsmb_window (
  input  wire logic [tsmb_pkg::TICK_W-1:0] cur_tick,
  input  wire logic [tsmb_pkg::TICK_W-1:0] tick,
  output tsmb_pkg::check_t                 chk
);

  logic [tsmb_pkg::DIFF_W-1:0] upper;
  logic [tsmb_pkg::DIFF_W-1:0] tick_ext;
  logic [tsmb_pkg::DIFF_W-1:0] cur_ext;

  always_comb begin
    tick_ext = {1'b0, tick};
    cur_ext  = {1'b0, cur_tick};
    upper    = tsmb_pkg::DIFF_W'(cur_ext + tsmb_pkg::DIFF_W'(tsmb_pkg::NUM_SLOTS - 1));
    if (tick < cur_tick) begin
      chk.status = tsmb_pkg::ST_LOW;
    end else if (tick_ext > upper) begin
      chk.status = tsmb_pkg::ST_HIGH;
    end else begin
      chk.status = tsmb_pkg::ST_OK;
    end
    chk.diff = $signed(tsmb_pkg::DIFF_W'(tick_ext - cur_ext));
    chk.slot = tsmb_pkg::SLOT_W'(tick % tsmb_pkg::NUM_SLOTS);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tick_slotted_message_buffer.sv =====
// ---------------------------------------------------------------------------
// Tick-slotted message buffer
// Timing wheel of per-tick message slots with push and drain commands.
// ---------------------------------------------------------------------------
// A push gives one result with its status and tick difference. A drain that
// is rejected, or that finds its slot empty, also gives one result. A valid
// drain of a slot holding n handles gives n results: the accepting cycle
// reads the first handle from the single read port of the message RAM, then
// one handle leaves per cycle while the output register is free. The input is
// stalled while a drain is streaming. Results go through one output register.
// A new item is taken only when that register is empty or its result
// transfers in the same cycle. The message RAM needs no clearing after reset:
// per-slot fill counts gate every read.
`timescale 1ns / 1ps
`default_nettype none

`include "tick_slotted_message_buffer_defines.svh"

module tick_slotted_message_buffer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [0:0]                            in_command,
  input  wire logic [tsmb_pkg::TICK_W-1:0]           in_tick_number,
  input  wire logic [tsmb_pkg::HANDLE_W-1:0]         in_message_handle,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [1:0]                                 out_status,
  output logic signed [tsmb_pkg::DIFF_W-1:0]         out_tick_difference,
  output logic [tsmb_pkg::HANDLE_W-1:0]              out_message_out,
  output logic                                       out_message_present,
  output logic                                       out_last,
  output logic [tsmb_pkg::TICK_W-1:0]                out_current_tick_out
);

  localparam int SLOT_W   = tsmb_pkg::SLOT_W;
  localparam int IDX_W    = tsmb_pkg::IDX_W;
  localparam int FILL_W   = tsmb_pkg::FILL_W;
  localparam int TICK_W   = tsmb_pkg::TICK_W;
  localparam int DIFF_W   = tsmb_pkg::DIFF_W;
  localparam int HANDLE_W = tsmb_pkg::HANDLE_W;
  localparam int ADDR_W   = tsmb_pkg::ADDR_W;

  tsmb_pkg::state_t  state_r, state_nxt;
  logic [TICK_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;

  logic [FILL_W-1:0] fill_cnt_r [tsmb_pkg::NUM_SLOTS];
  logic              fill_we;
  logic [SLOT_W-1:0] fill_wslot;
  logic [FILL_W-1:0] fill_wval;
  logic [FILL_W-1:0] fill_cur;

  logic                     out_valid_r, out_valid_nxt;
  tsmb_pkg::status_t        out_status_r, out_status_nxt;
  logic signed [DIFF_W-1:0] out_diff_r, out_diff_nxt;
  logic [HANDLE_W-1:0]      out_msg_r, out_msg_nxt;
  logic                     out_present_r, out_present_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [TICK_W-1:0]        out_cur_r, out_cur_nxt;

  logic              out_free;
  logic              in_acc;
  logic              drain_last;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HANDLE_W-1:0] ram_rdata;

  tsmb_pkg::check_t chk;

  tsmb_window u_window (
    .cur_tick (cur_r),
    .tick     (in_tick_number),
    .chk      (chk)
  );

  tsmb_ram #(
    .DEPTH (tsmb_pkg::STORE_DEPTH),
    .WIDTH (HANDLE_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_message_handle),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != tsmb_pkg::S_IDLE) || !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign fill_cur   = fill_cnt_r[chk.slot];
  assign drain_last = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;
  assign ram_waddr  = tsmb_pkg::store_addr(chk.slot, IDX_W'(fill_cur));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsmb_pkg::S_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    fill_r        <= fill_nxt;
    idx_r         <= idx_nxt;
    diff_r        <= diff_nxt;
    out_status_r  <= out_status_nxt;
    out_diff_r    <= out_diff_nxt;
    out_msg_r     <= out_msg_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
    out_cur_r     <= out_cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsmb_pkg::NUM_SLOTS; i++) begin
        fill_cnt_r[i] <= '0;
      end
    end else if (fill_we) begin
      fill_cnt_r[fill_wslot] <= fill_wval;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    slot_nxt        = slot_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    diff_nxt        = diff_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_diff_nxt    = out_diff_r;
    out_msg_nxt     = out_msg_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    out_cur_nxt     = out_cur_r;
    fill_we         = 1'b0;
    fill_wslot      = chk.slot;
    fill_wval       = '0;
    ram_we          = 1'b0;
    ram_raddr       = tsmb_pkg::store_addr(chk.slot, '0);

    unique case (state_r)
      tsmb_pkg::S_IDLE: begin
        if (in_acc) begin
          // single result unless a non-empty slot starts streaming
          out_valid_nxt   = 1'b1;
          out_status_nxt  = chk.status;
          out_diff_nxt    = chk.diff;
          out_msg_nxt     = '0;
          out_present_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          if (in_command == tsmb_pkg::CMD_PUSH) begin
            if (chk.status == tsmb_pkg::ST_OK) begin
              if (fill_cur >= FILL_W'(tsmb_pkg::SLOT_DEPTH)) begin
                out_status_nxt = tsmb_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                fill_we   = 1'b1;
                fill_wval = FILL_W'(fill_cur + FILL_W'(1));
              end
            end
            out_cur_nxt = cur_r;
          end else if (chk.status == tsmb_pkg::ST_OK) begin
            cur_nxt     = TICK_W'(cur_r + TICK_W'(1));
            out_cur_nxt = cur_nxt;
            fill_we     = 1'b1;
            fill_wval   = '0;
            if (fill_cur != '0) begin
              out_valid_nxt = out_valid_r && out_stall;
              state_nxt     = tsmb_pkg::S_DRAIN;
              slot_nxt      = chk.slot;
              fill_nxt      = fill_cur;
              idx_nxt       = '0;
              diff_nxt      = chk.diff;
            end
          end else begin
            out_cur_nxt = cur_r;
          end
        end
      end
      tsmb_pkg::S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = tsmb_pkg::ST_OK;
          out_diff_nxt    = diff_r;
          out_msg_nxt     = ram_rdata;
          out_present_nxt = 1'b1;
          out_last_nxt    = drain_last;
          out_cur_nxt     = cur_r;
          idx_nxt         = IDX_W'(idx_r + IDX_W'(1));
          if (drain_last) begin
            state_nxt = tsmb_pkg::S_IDLE;
          end
        end
        // read ahead so the next handle is ready on the following cycle
        ram_raddr = tsmb_pkg::store_addr(slot_r, idx_nxt);
      end
      default: begin
        state_nxt = tsmb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_tick_difference  = out_diff_r;
  assign out_message_out      = out_msg_r;
  assign out_message_present  = out_present_r;
  assign out_last             = out_last_r;
  assign out_current_tick_out = out_cur_r;

  `TSMB_ASSERT_IMP(a_drain_idx, clk, rst_n, state_r == tsmb_pkg::S_DRAIN,
                   (fill_r != '0) && (FILL_W'(idx_r) < fill_r))
  `TSMB_ASSERT_NXT(a_drain_end, clk, rst_n,
                   (state_r == tsmb_pkg::S_DRAIN) && out_free && drain_last,
                   state_r == tsmb_pkg::S_IDLE)
  `TSMB_ASSERT_NXT(a_tick_step, clk, rst_n, 1'b1,
                   (cur_r == $past(cur_r)) || (cur_r == TICK_W'($past(cur_r) + TICK_W'(1))))
  `TSMB_ASSERT_IMP(a_fill_limit, clk, rst_n, (state_r == tsmb_pkg::S_IDLE) && in_acc,
                   fill_cur <= FILL_W'(tsmb_pkg::SLOT_DEPTH))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Timing wheel buffer testbench
// Drives push and drain commands through the valid/stall input channel, keeps
// its own copy of the tick window, slot fill counts and stored handles to
// predict every result transfer, and compares each one field by field. Both
// channels idle at random, and the output is held off for a long stretch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int TICK_W     = tsmb_pkg::TICK_W;
  localparam int DIFF_W     = tsmb_pkg::DIFF_W;
  localparam int HANDLE_W   = tsmb_pkg::HANDLE_W;
  localparam int NUM_SLOTS  = tsmb_pkg::NUM_SLOTS;
  localparam int SLOT_DEPTH = tsmb_pkg::SLOT_DEPTH;

  typedef struct {
    tsmb_pkg::status_t         status;
    logic signed [DIFF_W-1:0]  diff;
    logic [HANDLE_W-1:0]       handle;
    logic                      present;
    logic                      last;
    logic [TICK_W-1:0]         tick_now;
  } wheel_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [0:0]                  in_command = tsmb_pkg::CMD_PUSH;
  logic [TICK_W-1:0]           in_tick_number = '0;
  logic [HANDLE_W-1:0]         in_message_handle = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  logic signed [DIFF_W-1:0]    out_tick_difference;
  logic [HANDLE_W-1:0]         out_message_out;
  logic                        out_message_present;
  logic                        out_last;
  logic [TICK_W-1:0]           out_current_tick_out;

  // wheel state as seen by the predictor
  logic [TICK_W-1:0]           wheel_tick = '0;
  int                          slot_fill [NUM_SLOTS];
  logic [HANDLE_W-1:0]         slot_store [NUM_SLOTS][SLOT_DEPTH];
  wheel_result_t               due_results [$];

  bit                          in_idle_on = 1'b1;
  bit                          out_idle_on = 1'b1;
  int                          hold_len = 0;

  int                          n_fail = 0;
  int                          n_items = 0;
  int                          n_checked = 0;
  int                          n_drained = 0;
  int                          status_seen [4];

  tick_slotted_message_buffer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_tick_number       (in_tick_number),
    .in_message_handle    (in_message_handle),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_tick_difference  (out_tick_difference),
    .out_message_out      (out_message_out),
    .out_message_present  (out_message_present),
    .out_last             (out_last),
    .out_current_tick_out (out_current_tick_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic predict_wheel(input tsmb_pkg::cmd_t cmd, input logic [TICK_W-1:0] tick,
                               input logic [HANDLE_W-1:0] handle);
    wheel_result_t     r;
    tsmb_pkg::status_t st;
    logic [TICK_W:0]   upper;
    int                slot;
    int                fill;
    upper = {1'b0, wheel_tick} + (TICK_W+1)'(NUM_SLOTS - 1);
    if (tick < wheel_tick) st = tsmb_pkg::ST_LOW;
    else if ({1'b0, tick} > upper) st = tsmb_pkg::ST_HIGH;
    else st = tsmb_pkg::ST_OK;
    slot = int'(tick % NUM_SLOTS);
    r.diff = {1'b0, tick} - {1'b0, wheel_tick};
    r.handle = '0;
    r.present = 1'b0;
    r.last = 1'b1;
    if (cmd == tsmb_pkg::CMD_PUSH && st == tsmb_pkg::ST_OK) begin
      if (slot_fill[slot] >= SLOT_DEPTH) begin
        st = tsmb_pkg::ST_FULL;
      end else begin
        slot_store[slot][slot_fill[slot]] = handle;
        slot_fill[slot]++;
      end
    end
    status_seen[st]++;
    if (cmd == tsmb_pkg::CMD_PUSH || st != tsmb_pkg::ST_OK) begin
      r.status = st;
      r.tick_now = wheel_tick;
      due_results.push_back(r);
      return;
    end
    fill = slot_fill[slot];
    slot_fill[slot] = 0;
    wheel_tick = wheel_tick + 1'b1;
    r.status = tsmb_pkg::ST_OK;
    r.tick_now = wheel_tick;
    if (fill == 0) begin
      due_results.push_back(r);
      return;
    end
    for (int i = 0; i < fill; i++) begin
      r.handle = slot_store[slot][i];
      r.present = 1'b1;
      r.last = (i == fill - 1);
      due_results.push_back(r);
      n_drained++;
    end
  endtask

  task automatic send_item(input tsmb_pkg::cmd_t cmd, input logic [TICK_W-1:0] tick,
                           input logic [HANDLE_W-1:0] handle);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_tick_number    <= tick;
    in_message_handle <= handle;
    do @(posedge clk); while (in_stall);
    predict_wheel(cmd, tick, handle);
    n_items++;
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    wheel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        want = due_results.pop_front();
        compare_field("status", 64'(want.status), 64'(out_status));
        compare_field("tick_difference", 64'(unsigned'(want.diff)),
                      64'(unsigned'(out_tick_difference)));
        compare_field("message_out", 64'(want.handle), 64'(out_message_out));
        compare_field("message_present", 64'(want.present), 64'(out_message_present));
        compare_field("last", 64'(want.last), 64'(out_last));
        compare_field("current_tick_out", 64'(want.tick_now), 64'(out_current_tick_out));
        n_checked++;
      end
    end
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else if (out_idle_on && $urandom_range(0, 2) == 0) begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic test_window_edges();
    send_item(tsmb_pkg::CMD_PUSH, 32'd0, 16'hFFFF);
    send_item(tsmb_pkg::CMD_PUSH, 32'd15, 16'h0000);
    send_item(tsmb_pkg::CMD_PUSH, 32'd16, 16'h1234);
    send_item(tsmb_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'hAAAA);
    send_item(tsmb_pkg::CMD_DRAIN, 32'd0, 16'h5555);
    send_item(tsmb_pkg::CMD_PUSH, 32'd0, 16'h0F0F);
    send_item(tsmb_pkg::CMD_DRAIN, 32'd0, 16'h0000);
    send_item(tsmb_pkg::CMD_DRAIN, 32'd17, 16'h0000);
    send_item(tsmb_pkg::CMD_DRAIN, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(tsmb_pkg::CMD_DRAIN, 32'd1, 16'h0000);
    // drain a tick well ahead of current, still inside the window
    send_item(tsmb_pkg::CMD_DRAIN, 32'd15, 16'h0000);
    send_item(tsmb_pkg::CMD_PUSH, 32'd18, 16'h5555);
    send_item(tsmb_pkg::CMD_DRAIN, 32'd18, 16'h0000);
  endtask

  task automatic test_slot_full();
    logic [TICK_W-1:0] tick;
    tick = wheel_tick + 32'd5;
    repeat (SLOT_DEPTH + 1) send_item(tsmb_pkg::CMD_PUSH, tick, HANDLE_W'($urandom));
    send_item(tsmb_pkg::CMD_DRAIN, tick, '0);
  endtask

  task automatic test_random_traffic(input int count);
    tsmb_pkg::cmd_t    cmd;
    logic [TICK_W-1:0] tick;
    int                r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        cmd = tsmb_pkg::CMD_PUSH;
        tick = wheel_tick + (($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(0, 15)));
      end else if (r < 78) begin
        cmd = tsmb_pkg::CMD_DRAIN;
        tick = wheel_tick + (($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 15)) : 32'd0);
      end else begin
        cmd = tsmb_pkg::cmd_t'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
          0: tick = $urandom;
          1: tick = wheel_tick - 32'($urandom_range(1, 3));
          default: tick = wheel_tick + 32'($urandom_range(16, 40));
        endcase
      end
      send_item(cmd, tick, HANDLE_W'($urandom));
    end
  endtask

  task automatic test_backpressure();
    logic [TICK_W-1:0] tick;
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    hold_len = 80;
    tick = wheel_tick + 32'd2;
    repeat (20) send_item(tsmb_pkg::CMD_PUSH, tick, HANDLE_W'($urandom));
    send_item(tsmb_pkg::CMD_DRAIN, wheel_tick, '0);
    send_item(tsmb_pkg::CMD_DRAIN, wheel_tick, '0);
    send_item(tsmb_pkg::CMD_DRAIN, tick, '0);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    foreach (slot_fill[i]) slot_fill[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_edges();
    test_slot_full();
    test_random_traffic(100);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random_traffic(70);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    test_backpressure();

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d command transfers and %0d result transfers, %0d handles drained.",
             n_items, n_checked, n_drained);
    $display("Statuses seen: ok %0d, too low %0d, too high %0d, slot full %0d.",
             status_seen[tsmb_pkg::ST_OK], status_seen[tsmb_pkg::ST_LOW],
             status_seen[tsmb_pkg::ST_HIGH], status_seen[tsmb_pkg::ST_FULL]);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tsmb_pkg.sv
hw/rtl/tsmb_ram.sv
hw/rtl/tsmb_window.sv
hw/rtl/tick_slotted_message_buffer.sv
tb/tb.sv
